/* design/vosc_pkg.sv */
package vosc_pkg;

  localparam int unsigned PaddrW = 4;

  localparam logic [1:0] REG_MAX_SLEW = 2'd0;
  localparam logic [1:0] REG_MIN_MOVE = 2'd1;
  localparam logic [1:0] REG_GLACIAL  = 2'd2;

  localparam logic [6:0] PC_FULL   = 7'd100;
  localparam logic [6:0] PC_MIN    = 7'd1;
  localparam logic [6:0] BAND_MIN  = 7'd7;
  localparam logic [6:0] VFAST_CAP = 7'd34;
  localparam logic [6:0] FAST_CAP  = 7'd20;
  localparam logic [6:0] AIM_GAIN  = 7'd6;
  localparam logic [4:0] AIM_TOP   = 5'd16;

  typedef struct packed {
    logic signed [11:0] temp_c16;
    logic [6:0]         target_temp_c;
    logic               bake_mode;
    logic               eco_bias;
    logic               hub_mode;
  } tick_t;

  typedef struct packed {
    logic [6:0] valve_percent;
    logic       changed;
    logic       cancel_bake;
  } result_t;

endpackage

/* design/valve_opening_slew_controller.sv */
// Result timing: a request's result is registered and shows in the cycle after the request is accepted.
// Throughput: one request per cycle; the request side stalls only while a held
// result is itself stalled.
// Reset (rst, synchronous, active high): valve closed, no result pending,
// registers max_slew_pc = 5, min_move_pc = 7, glacial = 0.
module valve_opening_slew_controller (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        tick_valid,
  output logic                        tick_stall,
  input  vosc_pkg::tick_t             tick,
  output logic                        result_valid,
  input  logic                        result_stall,
  output vosc_pkg::result_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vosc_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import vosc_pkg::*;

  logic [6:0] max_slew_pc;
  logic [6:0] min_move_pc;
  logic       glacial;
  logic [6:0] valve_open;
  logic [6:0] valve_open_next;
  logic       chg_next;
  logic       cancel_next;
  logic       tick_accept;
  logic       cfg_write;

  logic [6:0] mx;
  logic [6:0] band_cl;
  logic [6:0] band;
  logic [8:0] mx4;
  logic [7:0] mx2;
  logic [6:0] vfast;
  logic [6:0] fast;
  logic signed [7:0] deg;
  logic signed [8:0] deg_s;
  logic signed [8:0] tgt_s;
  logic [6:0] up_step;
  logic [7:0] up_sum;
  logic [4:0] aim_k;
  logic [6:0] aim;
  logic [6:0] err_dn;
  logic [6:0] err_up;
  logic [6:0] up_lim;

  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite && pready;
  assign tick_stall  = result_valid && result_stall;
  assign tick_accept = tick_valid && !tick_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_slew_pc <= 7'd5;
      min_move_pc <= 7'd7;
      glacial     <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_MAX_SLEW: max_slew_pc <= pwdata[6:0];
        REG_MIN_MOVE: min_move_pc <= pwdata[6:0];
        REG_GLACIAL:  glacial     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAX_SLEW: prdata = {25'd0, max_slew_pc};
      REG_MIN_MOVE: prdata = {25'd0, min_move_pc};
      REG_GLACIAL:  prdata = {31'd0, glacial};
      default:      prdata = 32'd0;
    endcase
  end

  always_comb begin
    mx      = (max_slew_pc < PC_MIN) ? PC_MIN :
              (max_slew_pc > PC_FULL) ? PC_FULL : max_slew_pc;
    band_cl = (min_move_pc < PC_MIN) ? PC_MIN :
              (min_move_pc > PC_FULL) ? PC_FULL : min_move_pc;
    band    = (band_cl < BAND_MIN) ? BAND_MIN : band_cl;
    mx4     = {mx, 2'b00};
    mx2     = {mx, 1'b0};
    if (glacial) begin
      vfast = mx;
      fast  = mx;
    end else begin
      vfast = (mx4 < {2'b00, VFAST_CAP}) ? mx4[6:0] : VFAST_CAP;
      fast  = (mx2 < {1'b0, FAST_CAP}) ? mx2[6:0] : FAST_CAP;
    end

    deg   = 8'(tick.temp_c16 >>> 4);
    deg_s = {deg[7], deg};
    tgt_s = signed'({2'b00, tick.target_temp_c});

    up_step = glacial ? mx : (tick.eco_bias ? fast : vfast);
    up_sum  = {1'b0, valve_open} + {1'b0, up_step};

    aim_k  = AIM_TOP - {1'b0, tick.temp_c16[3:0]};
    aim    = {2'b00, aim_k} * AIM_GAIN;
    err_dn = valve_open - aim;
    err_up = aim - valve_open;
    up_lim = glacial ? mx : ((tick.bake_mode || !tick.eco_bias) ? fast : mx);

    valve_open_next = valve_open;
    chg_next        = 1'b0;
    cancel_next     = 1'b0;

    if (deg_s < tgt_s) begin
      if (valve_open != PC_FULL) begin
        chg_next = 1'b1;
        if (tick.bake_mode && !glacial) begin
          valve_open_next = PC_FULL;
        end else begin
          valve_open_next = (up_sum < {1'b0, PC_FULL}) ? up_sum[6:0] : PC_FULL;
        end
      end
    end else if (deg_s > tgt_s) begin
      cancel_next = 1'b1;
      if (valve_open != 7'd0) begin
        chg_next = 1'b1;
        if ((!tick.eco_bias || tick.hub_mode) && valve_open > vfast) begin
          valve_open_next = valve_open - vfast;
        end else begin
          valve_open_next = 7'd0;
        end
      end
    end else begin
      if (aim < valve_open) begin
        if (err_dn >= band) begin
          chg_next        = 1'b1;
          valve_open_next = (err_dn > mx) ? valve_open - mx : aim;
        end
      end else if (aim > valve_open) begin
        if (err_up >= band) begin
          chg_next        = 1'b1;
          valve_open_next = (err_up > up_lim) ? valve_open + up_lim : aim;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valve_open   <= 7'd0;
      result_valid <= 1'b0;
    end else begin
      if (tick_accept) begin
        valve_open   <= valve_open_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      result.valve_percent <= valve_open_next;
      result.changed       <= chg_next;
      result.cancel_bake   <= cancel_next;
    end
  end

`ifndef SYNTHESIS
  a_valve_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.valve_percent <= PC_FULL)
    else $error("valve opening above full scale");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    tick_accept |=> result_valid && result.valve_percent == valve_open)
    else $error("result missing or out of step with valve state");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !tick_accept |=> valve_open == $past(valve_open))
    else $error("valve state moved without a request");

  a_cancel_closes: assert property (@(posedge clk) disable iff (rst)
    tick_accept |=> !(result.cancel_bake && result.changed &&
                      valve_open >= $past(valve_open)))
    else $error("over target but valve did not close");
`endif

endmodule

/* bench/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vosc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned ItemsPerSetting = 130;
  localparam int unsigned NumSettings = 8;
  localparam int unsigned NumSteps = 21;

  typedef struct packed {
    tick_t   req;
    logic    typed;
    result_t want;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        tick_valid = 1'b0;
  logic        tick_stall;
  tick_t       tick = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [6:0]  valve_pos = '0;
  logic [6:0]  slew_reg = 7'd5;
  logic [6:0]  move_reg = 7'd7;
  logic        glacial_reg = 1'b0;

  result_t     pending_valves [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 50;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;

  step_row_t steps [NumSteps] = '{
    '{'{12'h800, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b1, '{7'd20,  1'b1, 1'b0}},
    '{'{12'h800, 7'd127, 1'b1, 1'b0, 1'b0}, 1'b1, '{7'd100, 1'b1, 1'b0}},
    '{'{12'h800, 7'd127, 1'b0, 1'b0, 1'b0}, 1'b1, '{7'd100, 1'b0, 1'b0}},
    '{'{12'h7ff, 7'd127, 1'b0, 1'b0, 1'b0}, 1'b1, '{7'd95,  1'b1, 1'b0}},
    '{'{12'h7ff, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b1, '{7'd75,  1'b1, 1'b1}},
    '{'{12'h7ff, 7'd0,   1'b0, 1'b1, 1'b1}, 1'b1, '{7'd55,  1'b1, 1'b1}},
    '{'{12'h7ff, 7'd0,   1'b0, 1'b1, 1'b0}, 1'b1, '{7'd0,   1'b1, 1'b1}},
    '{'{12'h7ff, 7'd0,   1'b0, 1'b1, 1'b0}, 1'b1, '{7'd0,   1'b0, 1'b1}},
    '{'{12'h000, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b1, '{7'd10,  1'b1, 1'b0}},
    '{'{12'h000, 7'd0,   1'b0, 1'b1, 1'b0}, 1'b1, '{7'd15,  1'b1, 1'b0}},
    '{'{12'h000, 7'd0,   1'b1, 1'b1, 1'b0}, 1'b1, '{7'd25,  1'b1, 1'b0}},
    '{'{12'h05e, 7'd5,   1'b0, 1'b0, 1'b0}, 1'b1, '{7'd20,  1'b1, 1'b0}},
    '{'{12'h05e, 7'd5,   1'b0, 1'b0, 1'b0}, 1'b1, '{7'd15,  1'b1, 1'b0}},
    '{'{12'h05e, 7'd5,   1'b0, 1'b0, 1'b0}, 1'b1, '{7'd15,  1'b0, 1'b0}},
    '{'{12'hfff, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b1, '{7'd35,  1'b1, 1'b0}},
    '{'{12'hff0, 7'd0,   1'b0, 1'b1, 1'b0}, 1'b1, '{7'd45,  1'b1, 1'b0}},
    '{'{12'h039, 7'd3,   1'b0, 1'b0, 1'b0}, 1'b1, '{7'd45,  1'b0, 1'b0}},
    '{'{12'h033, 7'd3,   1'b0, 1'b1, 1'b0}, 1'b1, '{7'd50,  1'b1, 1'b0}},
    '{'{12'h036, 7'd3,   1'b0, 1'b0, 1'b0}, 1'b1, '{7'd60,  1'b1, 1'b0}},
    '{'{12'h7ff, 7'd127, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
    '{'{12'h800, 7'd0,   1'b1, 1'b1, 1'b1}, 1'b0, '0}
  };

  valve_opening_slew_controller u_dut (
    .clk         (clk),
    .rst         (rst),
    .tick_valid  (tick_valid),
    .tick_stall  (tick_stall),
    .tick        (tick),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic result_t predict_valve(tick_t t);
    logic signed [11:0] tv;
    int mx, band, vfast, fast, lim, deg, aim, pos, err;
    result_t r;
    mx = (slew_reg == 0) ? 1 : (slew_reg > 100) ? 100 : int'(slew_reg);
    band = (move_reg == 0) ? 1 : (move_reg > 100) ? 100 : int'(move_reg);
    if (band < 7) band = 7;
    if (glacial_reg) begin
      vfast = mx;
      fast = mx;
    end else begin
      vfast = (4 * mx < 34) ? 4 * mx : 34;
      fast = (2 * mx < 20) ? 2 * mx : 20;
    end
    pos = int'(valve_pos);
    if (pos > 100) pos = 100;
    tv = t.temp_c16;
    deg = int'(tv) >>> 4;
    r = '0;
    if (deg < int'(t.target_temp_c)) begin
      if (pos != 100) begin
        if (t.bake_mode && !glacial_reg) begin
          pos = 100;
        end else begin
          pos = pos + (glacial_reg ? mx : (t.eco_bias ? fast : vfast));
          if (pos > 100) pos = 100;
        end
        r.changed = 1'b1;
      end
    end else if (deg > int'(t.target_temp_c)) begin
      r.cancel_bake = 1'b1;
      if (pos != 0) begin
        if ((!t.eco_bias || t.hub_mode) && pos > vfast) pos = pos - vfast;
        else pos = 0;
        r.changed = 1'b1;
      end
    end else begin
      aim = (16 - int'(t.temp_c16[3:0])) * 6;
      if (aim < pos) begin
        err = pos - aim;
        if (err >= band) begin
          pos = (err > mx) ? pos - mx : aim;
          r.changed = 1'b1;
        end
      end else if (aim > pos) begin
        err = aim - pos;
        if (err >= band) begin
          lim = glacial_reg ? mx : ((t.bake_mode || !t.eco_bias) ? fast : mx);
          pos = (err > lim) ? pos + lim : aim;
          r.changed = 1'b1;
        end
      end
    end
    valve_pos = 7'(pos);
    r.valve_percent = valve_pos;
    return r;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int tgt, deg, kind;
    tgt = int'($urandom_range(127));
    kind = int'($urandom_range(9));
    if (kind < 5) deg = tgt;
    else if (kind < 7) deg = tgt - int'($urandom_range(3, 1));
    else deg = tgt + int'($urandom_range(3, 1));
    if (deg > 127) deg = 127;
    t.target_temp_c = 7'(tgt);
    if (kind == 9) t.temp_c16 = 12'($urandom);
    else t.temp_c16 = 12'(deg * 16 + int'($urandom_range(15)));
    t.bake_mode = ($urandom_range(3) == 0);
    t.eco_bias = 1'($urandom_range(1));
    t.hub_mode = 1'($urandom_range(1));
    return t;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_request(tick_t t, logic typed, result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      @(negedge clk);
    end
    tick_valid <= 1'b1;
    tick <= t;
    do @(posedge clk); while (tick_stall);
    predicted = predict_valve(t);
    pending_valves.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    tick_valid <= 1'b0;
    @(negedge clk);
    while (pending_valves.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    logic [31:0] wd;
    wd = $urandom;
    wd[6:0] = val;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= wd;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MAX_SLEW: slew_reg = wd[6:0];
      REG_MIN_MOVE: move_reg = wd[6:0];
      REG_GLACIAL:  glacial_reg = wd[0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_valves.size() == 0) begin
        flag_mismatch("unexpected result, valve_percent", int'(result.valve_percent), -1);
      end else begin
        want = pending_valves.pop_front();
        if (result.valve_percent !== want.valve_percent)
          flag_mismatch("valve_percent", int'(result.valve_percent), int'(want.valve_percent));
        if (result.changed !== want.changed)
          flag_mismatch("changed", int'(result.changed), int'(want.changed));
        if (result.cancel_bake !== want.cancel_bake)
          flag_mismatch("cancel_bake", int'(result.cancel_bake), int'(want.cancel_bake));
      end
    end
  end

  initial begin
    int slew_set [NumSettings] = '{5, 0, 127, 1, 100, 3, 17, 9};
    int move_set [NumSettings] = '{7, 0, 127, 1, 100, 12, 101, 5};
    int glac_set [NumSettings] = '{0, 0, 0, 1, 1, 0, 1, 1};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (steps[i]) send_request(steps[i].req, steps[i].typed, steps[i].want);

    for (int p = 0; p < NumSettings; p++) begin
      if (p < 3) begin
        send_idle_pct = 31;
        recv_idle_pct = 50;
      end else if (p < 6) begin
        send_idle_pct = 50;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_quiet();
      write_reg(REG_MAX_SLEW, 7'(slew_set[p]));
      write_reg(REG_MIN_MOVE, 7'(move_set[p]));
      write_reg(REG_GLACIAL, 7'(glac_set[p]));
      @(negedge clk);
      for (int n = 0; n < ItemsPerSetting; n++) begin
        if (p == 0 && n == 40) hold_request = 1'b1;
        send_request(random_tick(), 1'b0, '0);
      end
    end

    wait_quiet();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* valve_opening_slew_controller.f */
design/vosc_pkg.sv
design/valve_opening_slew_controller.sv
bench/testbench.sv
